// ===== hw/rtl/lisd_pkg.sv =====
// Shared types and constants for the layered image stream decoder.
// No dependencies; the other files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package lisd_pkg;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_SEC_LEN  = 4'd1,
    PH_SEC_SKIP = 4'd2,
    PH_COMP     = 4'd3,
    PH_RAW      = 4'd4,
    PH_LENS     = 4'd5,
    PH_CMD      = 4'd6,
    PH_LIT      = 4'd7,
    PH_REP      = 4'd8,
    PH_DONE     = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_FINAL  = 2'd2
  } kind_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_HDR   = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_BAD_COMP  = 3'd3;
  localparam logic [2:0] ST_OVERRUN   = 3'd4;
  localparam logic [2:0] ST_ROW_MISM  = 3'd5;
  localparam logic [2:0] ST_TOO_LARGE = 3'd6;

  localparam logic [31:0] SIGNATURE   = 32'h3842_5053;  // "8BPS"
  localparam logic [15:0] DEPTH_8     = 16'd8;
  localparam logic [15:0] MODE_INDEX  = 16'd2;
  localparam logic [15:0] CH_LIMIT    = 16'd4;
  localparam logic [7:0]  PB_NOP      = 8'd128;
  localparam logic [8:0]  PB_REP_BASE = 9'd257;

  localparam logic [4:0]  HI_SIG      = 5'd3;
  localparam logic [4:0]  HI_CHAN     = 5'd13;
  localparam logic [4:0]  HI_HEIGHT   = 5'd17;
  localparam logic [4:0]  HI_WIDTH    = 5'd21;
  localparam logic [4:0]  HI_DEPTH    = 5'd23;
  localparam logic [4:0]  HI_MODE     = 5'd25;

  localparam logic [1:0]  CFG_ROW_PITCH = 2'd0;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] byte_address;
    logic [7:0]  run_length;
    logic [7:0]  pixel_value;
    logic [2:0]  status;
    logic [14:0] image_width;
    logic [12:0] image_height;
    logic [2:0]  channel_count;
  } res_t;

endpackage

// ===== hw/rtl/lisd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lisd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/lisd_cfg.sv =====
// APB-style register port holding row_pitch.
// Depends on lisd_pkg.
`timescale 1ns / 1ps

module lisd_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [19:0] row_pitch
);

  logic [19:0] pitch_r;
  logic        sel_pitch;

  assign sel_pitch = (paddr[2] == lisd_pkg::CFG_ROW_PITCH[0]);
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= '0;
    end else if (psel && penable && pwrite && sel_pitch) begin
      pitch_r <= pwdata[19:0];
    end
  end

  assign prdata    = sel_pitch ? {12'd0, pitch_r} : 32'd0;
  assign row_pitch = pitch_r;

endmodule

// ===== hw/rtl/lisd_obuf.sv =====
// Two-deep result buffer: output register plus skid entry.
// Depends on lisd_pkg.
`timescale 1ns / 1ps

module lisd_obuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lisd_pkg::res_t  push_data,
  output logic            can_push,
  output logic            out_valid,
  input  logic            out_ready,
  output lisd_pkg::res_t  out_data
);

  logic           out_v_r, skid_v_r;
  lisd_pkg::res_t out_d_r, skid_d_r;
  logic           pop;

  assign pop      = out_v_r && out_ready;
  assign can_push = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_d_r <= skid_d_r;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_d_r <= push_data;
      end else begin
        skid_d_r <= push_data;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

// ===== hw/rtl/layered_image_stream_decoder_core.sv =====
// Top level: byte-stream decoder for 8-bit layered images, raw or PackBits.
// Depends on lisd_pkg, lisd_ram, lisd_cfg, lisd_obuf.
//
//  channel | ports                      | beat carries
//  --------+----------------------------+---------------------------------------
//  in      | in_tvalid/tready/tdata/tlast | one file byte, tlast on final byte
//  out     | out_tvalid/tready/tdata/tuser| run write, header info or final status
//  cfg     | cfg_psel..cfg_pready (APB) | row_pitch at byte address 0
//
// One byte is taken per cycle while not stalled; its result is registered in the result buffer.
// Row lengths live in a RAM; the next row's length is read ahead so a row
// may start on every byte. Input stalls only when both result slots are
// full. Reset (synchronous) returns to header parsing; no clearing pass.
`timescale 1ns / 1ps

module layered_image_stream_decoder_core #(
  parameter int MAX_WIDTH    = 16384,
  parameter int MAX_HEIGHT   = 4096,
  parameter int MAX_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] byte_address, [39:32] run_length, [47:40] pixel_value,
  // [50:48] status, [65:51] image_width, [78:66] image_height,
  // [81:79] channel_count, [87:82] zero
  output logic [87:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] kind
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int WCL   = $clog2(MAX_WIDTH + 1);
  localparam int HCL   = $clog2(MAX_HEIGHT + 1);
  localparam int WW    = (WCL > 15) ? WCL : 15;
  localparam int HW    = (HCL > 13) ? HCL : 13;
  localparam int CW    = WW + 2;
  localparam int DEPTH = (MAX_HEIGHT * MAX_CHANNELS < 2) ? 2 : MAX_HEIGHT * MAX_CHANNELS;
  localparam int IW    = $clog2(DEPTH);
  localparam logic [31:0] MAXW32 = 32'(MAX_WIDTH);
  localparam logic [31:0] MAXH32 = 32'(MAX_HEIGHT);
  localparam logic [15:0] MAXC16 = 16'(MAX_CHANNELS);

  // ---------------- registers ----------------
  lisd_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]    hidx_r, hidx_nxt;
  logic [31:0]   fshift_r, fshift_nxt;
  logic [WW-1:0] width_r, width_nxt;
  logic [HW-1:0] height_r, height_nxt;
  logic [2:0]    chan_r, chan_nxt;
  logic [2:0]    hstat_r, hstat_nxt;
  logic [31:0]   sec_left_r, sec_left_nxt;
  logic [1:0]    sec_num_r, sec_num_nxt;
  logic [2:0]    cur_ch_r, cur_ch_nxt;
  logic [HW-1:0] cur_row_r, cur_row_nxt;
  logic [WW-1:0] cur_col_r, cur_col_nxt;
  logic [CW-1:0] col_off_r, col_off_nxt;
  logic [15:0]   rbl_r, rbl_nxt;
  logic [7:0]    lit_r, lit_nxt;
  logic [7:0]    rep_r, rep_nxt;
  logic [31:0]   base_r, base_nxt;
  logic [IW-1:0] wr_idx_r, wr_idx_nxt;
  logic [IW-1:0] nx_idx_r, nx_idx_nxt;
  logic          byp_r;
  logic [15:0]   byp_d_r;

  // ---------------- misc ----------------
  logic [19:0]    row_pitch;
  logic           acc, can_push, res_valid;
  lisd_pkg::res_t res, obuf_data;
  logic           ram_we;
  logic [15:0]    ram_wdata, ram_rdata, len_src;

  lisd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready),
    .row_pitch (row_pitch)
  );

  lisd_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_lens (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (ram_wdata),
    .raddr (nx_idx_nxt),
    .rdata (ram_rdata)
  );

  lisd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (obuf_data)
  );

  assign in_tready = can_push;
  assign acc       = in_tvalid && can_push;
  assign out_tuser = obuf_data.kind;
  assign out_tdata = {6'd0, obuf_data.channel_count, obuf_data.image_height,
                      obuf_data.image_width, obuf_data.status, obuf_data.pixel_value,
                      obuf_data.run_length, obuf_data.byte_address};

  // Row length for a row starting now: same-cycle write, last-cycle write, or RAM.
  assign len_src = (ram_we && (wr_idx_r == nx_idx_r)) ? ram_wdata :
                   byp_r ? byp_d_r : ram_rdata;

  // ---------------- next state ----------------
  logic [31:0]   v;
  logic [2:0]    mk;
  logic          fail_v;
  logic [2:0]    fail_code;
  logic          do_rec, do_nr, do_start, img_done;
  logic [15:0]   rec_rbl, rbl1;
  logic [WW-1:0] rec_col;
  logic [7:0]    count;
  logic [WW:0]   col_end;
  logic          ev_v;
  lisd_pkg::kind_t ev_kind;
  logic [2:0]    ev_status;
  logic [31:0]   ev_addr;
  logic [7:0]    ev_len, ev_val;

  always_comb begin
    phase_nxt    = phase_r;
    hidx_nxt     = hidx_r;
    fshift_nxt   = fshift_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    chan_nxt     = chan_r;
    hstat_nxt    = hstat_r;
    sec_left_nxt = sec_left_r;
    sec_num_nxt  = sec_num_r;
    cur_ch_nxt   = cur_ch_r;
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    col_off_nxt  = col_off_r;
    rbl_nxt      = rbl_r;
    lit_nxt      = lit_r;
    rep_nxt      = rep_r;
    base_nxt     = base_r;
    wr_idx_nxt   = wr_idx_r;
    nx_idx_nxt   = nx_idx_r;
    ram_we       = 1'b0;
    v            = {fshift_r[23:0], in_tdata};
    ram_wdata    = v[15:0];
    mk           = 3'd0;
    fail_v       = 1'b0;
    fail_code    = lisd_pkg::ST_OK;
    do_rec       = 1'b0;
    do_nr        = 1'b0;
    do_start     = 1'b0;
    img_done     = 1'b0;
    rec_rbl      = rbl_r;
    rec_col      = cur_col_r;
    rbl1         = rbl_r - 16'd1;
    count        = 8'd0;
    col_end      = '0;
    ev_v         = 1'b0;
    ev_kind      = lisd_pkg::KIND_WRITE;
    ev_status    = lisd_pkg::ST_OK;
    ev_addr      = base_r + 32'(col_off_r) + 32'(cur_ch_r);
    ev_len       = 8'd0;
    ev_val       = in_tdata;

    if (acc && phase_r != lisd_pkg::PH_DONE) begin
      case (phase_r)
        lisd_pkg::PH_HEADER: begin
          fshift_nxt = v;
          case (hidx_r)
            lisd_pkg::HI_SIG: begin
              if (v != lisd_pkg::SIGNATURE) mk = lisd_pkg::ST_BAD_HDR;
            end
            lisd_pkg::HI_CHAN: begin
              if (v[15:0] == 16'd0 || v[15:0] > lisd_pkg::CH_LIMIT) begin
                mk = lisd_pkg::ST_BAD_HDR;
              end else if (v[15:0] > MAXC16) begin
                mk = lisd_pkg::ST_TOO_LARGE;
              end
              chan_nxt = v[2:0];
            end
            lisd_pkg::HI_HEIGHT, lisd_pkg::HI_WIDTH: begin
              if (v == 32'd0 || v[31]) begin
                mk = lisd_pkg::ST_BAD_HDR;
              end else if (v > ((hidx_r == lisd_pkg::HI_HEIGHT) ? MAXH32 : MAXW32)) begin
                mk = lisd_pkg::ST_TOO_LARGE;
              end
              if (hidx_r == lisd_pkg::HI_HEIGHT) height_nxt = v[HW-1:0];
              else width_nxt = v[WW-1:0];
            end
            lisd_pkg::HI_DEPTH: begin
              if (v[15:0] != lisd_pkg::DEPTH_8) mk = lisd_pkg::ST_BAD_HDR;
            end
            lisd_pkg::HI_MODE: begin
              if (v[15:0] == lisd_pkg::MODE_INDEX) mk = lisd_pkg::ST_BAD_HDR;
            end
            default: ;
          endcase
          // bad header outranks too large
          if (mk == lisd_pkg::ST_BAD_HDR) hstat_nxt = lisd_pkg::ST_BAD_HDR;
          else if (hstat_r == lisd_pkg::ST_OK) hstat_nxt = mk;
          if (hidx_r == lisd_pkg::HI_MODE) begin
            if (hstat_nxt != lisd_pkg::ST_OK) begin
              width_nxt  = '0;
              height_nxt = '0;
              chan_nxt   = '0;
              fail_v     = 1'b1;
              fail_code  = hstat_nxt;
            end else begin
              ev_v        = 1'b1;
              ev_kind     = lisd_pkg::KIND_HEADER;
              hidx_nxt    = 5'd0;
              sec_num_nxt = 2'd0;
              phase_nxt   = lisd_pkg::PH_SEC_LEN;
            end
          end else begin
            hidx_nxt = hidx_r + 5'd1;
          end
        end
        lisd_pkg::PH_SEC_LEN: begin
          fshift_nxt = v;
          hidx_nxt   = hidx_r + 5'd1;
          if (hidx_r >= 5'd3) begin
            sec_left_nxt = v;
            hidx_nxt     = 5'd0;
            if (v == 32'd0) begin
              sec_num_nxt = sec_num_r + 2'd1;
              phase_nxt   = (sec_num_r >= 2'd2) ? lisd_pkg::PH_COMP : lisd_pkg::PH_SEC_LEN;
            end else begin
              phase_nxt = lisd_pkg::PH_SEC_SKIP;
            end
          end
        end
        lisd_pkg::PH_SEC_SKIP: begin
          sec_left_nxt = sec_left_r - 32'd1;
          if (sec_left_r == 32'd1) begin
            sec_num_nxt = sec_num_r + 2'd1;
            hidx_nxt    = 5'd0;
            phase_nxt   = (sec_num_r >= 2'd2) ? lisd_pkg::PH_COMP : lisd_pkg::PH_SEC_LEN;
          end
        end
        lisd_pkg::PH_COMP: begin
          fshift_nxt = v;
          hidx_nxt   = hidx_r + 5'd1;
          if (hidx_r >= 5'd1) begin
            hidx_nxt    = 5'd0;
            cur_ch_nxt  = '0;
            cur_row_nxt = '0;
            cur_col_nxt = '0;
            col_off_nxt = '0;
            base_nxt    = '0;
            wr_idx_nxt  = '0;
            nx_idx_nxt  = '0;
            if (v[15:0] > 16'd1) begin
              fail_v    = 1'b1;
              fail_code = lisd_pkg::ST_BAD_COMP;
            end else begin
              phase_nxt = (v[15:0] == 16'd0) ? lisd_pkg::PH_RAW : lisd_pkg::PH_LENS;
            end
          end
        end
        lisd_pkg::PH_RAW: begin
          ev_v        = 1'b1;
          ev_len      = 8'd1;
          cur_col_nxt = cur_col_r + 1'b1;
          col_off_nxt = col_off_r + CW'(chan_r);
          if ({1'b0, cur_col_r} + 1'b1 >= {1'b0, width_r}) do_nr = 1'b1;
        end
        lisd_pkg::PH_LENS: begin
          fshift_nxt = v;
          hidx_nxt   = hidx_r ^ 5'd1;
          if (hidx_r[0]) begin
            ram_we      = 1'b1;
            wr_idx_nxt  = wr_idx_r + 1'b1;
            cur_row_nxt = cur_row_r + 1'b1;
            if ({1'b0, cur_row_r} + 1'b1 >= {1'b0, height_r}) begin
              cur_row_nxt = '0;
              cur_ch_nxt  = cur_ch_r + 3'd1;
              if ({1'b0, cur_ch_r} + 4'd1 >= {1'b0, chan_r}) begin
                cur_ch_nxt  = '0;
                cur_col_nxt = '0;
                col_off_nxt = '0;
                base_nxt    = '0;
                do_start    = 1'b1;
              end
            end
          end
        end
        lisd_pkg::PH_CMD: begin
          if (rbl_r == 16'd0) begin
            fail_v    = 1'b1;
            fail_code = lisd_pkg::ST_ROW_MISM;
          end else begin
            rbl_nxt = rbl1;
            if (in_tdata == lisd_pkg::PB_NOP) begin
              do_rec  = 1'b1;
              rec_rbl = rbl1;
            end else begin
              count   = in_tdata[7] ? 8'(lisd_pkg::PB_REP_BASE - {1'b0, in_tdata})
                                    : in_tdata + 8'd1;
              col_end = {1'b0, cur_col_r} + (WW+1)'(count);
              if ((in_tdata[7] ? 16'd1 : {8'd0, count}) > rbl1) begin
                fail_v    = 1'b1;
                fail_code = lisd_pkg::ST_ROW_MISM;
              end else if (col_end > {1'b0, width_r}) begin
                fail_v    = 1'b1;
                fail_code = lisd_pkg::ST_OVERRUN;
              end else if (!in_tdata[7]) begin
                lit_nxt   = count;
                phase_nxt = lisd_pkg::PH_LIT;
              end else begin
                rep_nxt   = count;
                phase_nxt = lisd_pkg::PH_REP;
              end
            end
          end
        end
        lisd_pkg::PH_LIT: begin
          rbl_nxt     = rbl1;
          ev_v        = 1'b1;
          ev_len      = 8'd1;
          cur_col_nxt = cur_col_r + 1'b1;
          col_off_nxt = col_off_r + CW'(chan_r);
          lit_nxt     = lit_r - 8'd1;
          if (lit_r == 8'd1) begin
            phase_nxt = lisd_pkg::PH_CMD;
            do_rec    = 1'b1;
            rec_rbl   = rbl1;
            rec_col   = cur_col_r + 1'b1;
          end
        end
        lisd_pkg::PH_REP: begin
          rbl_nxt     = rbl1;
          ev_v        = 1'b1;
          ev_len      = rep_r;
          cur_col_nxt = cur_col_r + WW'(rep_r);
          col_off_nxt = col_off_r + CW'(rep_r) * CW'(chan_r);
          phase_nxt   = lisd_pkg::PH_CMD;
          do_rec      = 1'b1;
          rec_rbl     = rbl1;
          rec_col     = cur_col_r + WW'(rep_r);
        end
        default: ;
      endcase

      // end of row data
      if (do_rec && rec_rbl == 16'd0) begin
        if (rec_col != width_r) begin
          fail_v    = 1'b1;
          fail_code = lisd_pkg::ST_ROW_MISM;
        end else begin
          do_nr = 1'b1;
        end
      end

      if (do_nr) begin
        cur_col_nxt = '0;
        col_off_nxt = '0;
        cur_row_nxt = cur_row_r + 1'b1;
        base_nxt    = base_r + 32'(row_pitch);
        if ({1'b0, cur_row_r} + 1'b1 >= {1'b0, height_r}) begin
          cur_row_nxt = '0;
          base_nxt    = '0;
          cur_ch_nxt  = cur_ch_r + 3'd1;
          if ({1'b0, cur_ch_r} + 4'd1 >= {1'b0, chan_r}) begin
            img_done  = 1'b1;
            ev_v      = 1'b1;
            ev_kind   = lisd_pkg::KIND_FINAL;
            ev_status = lisd_pkg::ST_OK;
            phase_nxt = lisd_pkg::PH_DONE;
          end
        end
        if (!img_done && phase_r != lisd_pkg::PH_RAW) do_start = 1'b1;
      end

      if (do_start) begin
        rbl_nxt    = len_src;
        phase_nxt  = lisd_pkg::PH_CMD;
        nx_idx_nxt = nx_idx_r + 1'b1;
        if (len_src == 16'd0) begin
          fail_v    = 1'b1;
          fail_code = lisd_pkg::ST_ROW_MISM;
        end
      end

      if (in_tlast && !fail_v && !img_done) begin
        fail_v    = 1'b1;
        fail_code = (phase_nxt == lisd_pkg::PH_HEADER) ? lisd_pkg::ST_BAD_HDR
                                                       : lisd_pkg::ST_TRUNC;
      end

      if (fail_v) begin
        ev_v      = 1'b1;
        ev_kind   = lisd_pkg::KIND_FINAL;
        ev_status = fail_code;
        ev_addr   = 32'd0;
        ev_len    = 8'd0;
        ev_val    = 8'd0;
        phase_nxt = lisd_pkg::PH_DONE;
      end
    end
  end

  // ---------------- result ----------------
  always_comb begin
    res_valid         = acc && ev_v;
    res.kind          = ev_kind;
    res.byte_address  = (ev_kind == lisd_pkg::KIND_HEADER) ? 32'd0 : ev_addr;
    res.run_length    = ev_len;
    res.pixel_value   = (ev_kind == lisd_pkg::KIND_HEADER) ? 8'd0 : ev_val;
    res.status        = ev_status;
    res.image_width   = width_nxt[14:0];
    res.image_height  = height_nxt[12:0];
    res.channel_count = chan_nxt;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_tlast)) begin
      phase_r    <= lisd_pkg::PH_HEADER;
      hidx_r     <= '0;
      fshift_r   <= '0;
      width_r    <= '0;
      height_r   <= '0;
      chan_r     <= '0;
      hstat_r    <= '0;
      sec_left_r <= '0;
      sec_num_r  <= '0;
      cur_ch_r   <= '0;
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      col_off_r  <= '0;
      rbl_r      <= '0;
      lit_r      <= '0;
      rep_r      <= '0;
      base_r     <= '0;
      wr_idx_r   <= '0;
      nx_idx_r   <= '0;
    end else begin
      phase_r    <= phase_nxt;
      hidx_r     <= hidx_nxt;
      fshift_r   <= fshift_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      chan_r     <= chan_nxt;
      hstat_r    <= hstat_nxt;
      sec_left_r <= sec_left_nxt;
      sec_num_r  <= sec_num_nxt;
      cur_ch_r   <= cur_ch_nxt;
      cur_row_r  <= cur_row_nxt;
      cur_col_r  <= cur_col_nxt;
      col_off_r  <= col_off_nxt;
      rbl_r      <= rbl_nxt;
      lit_r      <= lit_nxt;
      rep_r      <= rep_nxt;
      base_r     <= base_nxt;
      wr_idx_r   <= wr_idx_nxt;
      nx_idx_r   <= nx_idx_nxt;
    end
  end

  // RAM returns old data when read and written at one address in a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= ram_we && (wr_idx_r == nx_idx_nxt);
    end
    byp_d_r <= ram_wdata;
  end

endmodule

// ===== sim/testbench.sv =====
// Testbench for layered_image_stream_decoder_core: builds small image files (raw and
// PackBits), streams them byte by byte and checks every result beat against a predictor.
// Depends on lisd_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_CH = 4;
  localparam int MAX_W = 16384;
  localparam int MAX_H = 4096;
  localparam int STORE_N = MAX_H * MAX_CH;
  localparam int N_ITEMS = 1550;

  // Decoder model plus the queue of results it still expects.
  class decode_scoreboard;
    lisd_pkg::res_t exp_q[$];
    int mismatches;
    bit [31:0] pitch;
    lisd_pkg::phase_t stage;
    bit [31:0] hidx, shreg, w, h, ch, hstat, sec_left, sec_no;
    bit [31:0] chan, row, col, row_left, lit_left, rep_cnt, base;
    bit [15:0] lens[STORE_N];
    bit ev_on;
    lisd_pkg::kind_t ev_kind;
    bit [2:0] ev_st;
    bit [31:0] ev_addr, ev_len, ev_val;

    function new();
      pitch = 0;
      mismatches = 0;
      idle_all();
    endfunction

    function int pending();
      return exp_q.size();
    endfunction

    function void idle_all();
      stage = lisd_pkg::PH_HEADER;
      hidx = 0; shreg = 0; w = 0; h = 0; ch = 0; hstat = 0;
      sec_left = 0; sec_no = 0; chan = 0; row = 0; col = 0;
      row_left = 0; lit_left = 0; rep_cnt = 0; base = 0;
    endfunction

    function void mark(bit [2:0] s);
      if (s == lisd_pkg::ST_BAD_HDR) hstat = 32'(lisd_pkg::ST_BAD_HDR);
      else if (hstat == 0) hstat = 32'(s);
    endfunction

    function void fail(bit [2:0] s);
      ev_on = 1; ev_kind = lisd_pkg::KIND_FINAL; ev_st = s;
      ev_addr = 0; ev_len = 0; ev_val = 0;
      stage = lisd_pkg::PH_DONE;
    endfunction

    function void emit(bit [31:0] n, bit [7:0] v);
      ev_on = 1; ev_kind = lisd_pkg::KIND_WRITE;
      ev_addr = base + col * ch + chan;
      ev_len = n; ev_val = 32'(v);
    endfunction

    // true once the last row of the last plane is done
    function bit next_row();
      col = 0;
      row++;
      base += pitch;
      if (row >= h) begin
        row = 0; base = 0; chan++;
        if (chan >= ch) begin
          ev_on = 1; ev_kind = lisd_pkg::KIND_FINAL; ev_st = lisd_pkg::ST_OK;
          stage = lisd_pkg::PH_DONE;
          return 1;
        end
      end
      return 0;
    endfunction

    function void start_row();
      bit [31:0] idx;
      idx = chan * h + row;
      row_left = (idx < STORE_N) ? 32'(lens[idx[13:0]]) : 32'd0;
      stage = lisd_pkg::PH_CMD;
      if (row_left == 0) fail(lisd_pkg::ST_ROW_MISM);
    endfunction

    function void row_end_check();
      if (row_left != 0) return;
      if (col != w) fail(lisd_pkg::ST_ROW_MISM);
      else if (!next_row()) start_row();
    endfunction

    function void section_done();
      sec_no++;
      hidx = 0;
      stage = (sec_no >= 3) ? lisd_pkg::PH_COMP : lisd_pkg::PH_SEC_LEN;
    endfunction

    function void step(bit [7:0] b, bit last);
      bit [31:0] v, cnt, need, idx;
      lisd_pkg::res_t r;
      ev_on = 0; ev_kind = lisd_pkg::KIND_WRITE; ev_st = lisd_pkg::ST_OK;
      ev_addr = 0; ev_len = 0; ev_val = 0;
      if (stage == lisd_pkg::PH_DONE) begin
        if (last) idle_all();
        return;
      end
      case (stage)
        lisd_pkg::PH_HEADER: begin
          shreg = {shreg[23:0], b};
          v = shreg;
          case (hidx)
            lisd_pkg::HI_SIG: if (v != lisd_pkg::SIGNATURE) mark(lisd_pkg::ST_BAD_HDR);
            lisd_pkg::HI_CHAN: begin
              v = v & 32'hFFFF;
              if (v == 0 || v > lisd_pkg::CH_LIMIT) mark(lisd_pkg::ST_BAD_HDR);
              else if (v > MAX_CH) mark(lisd_pkg::ST_TOO_LARGE);
              ch = v;
            end
            lisd_pkg::HI_HEIGHT, lisd_pkg::HI_WIDTH: begin
              if (v == 0 || v[31]) mark(lisd_pkg::ST_BAD_HDR);
              else if (v > ((hidx == lisd_pkg::HI_HEIGHT) ? MAX_H : MAX_W))
                mark(lisd_pkg::ST_TOO_LARGE);
              if (hidx == lisd_pkg::HI_HEIGHT) h = v;
              else w = v;
            end
            lisd_pkg::HI_DEPTH: if (v[15:0] != lisd_pkg::DEPTH_8) mark(lisd_pkg::ST_BAD_HDR);
            lisd_pkg::HI_MODE: if (v[15:0] == lisd_pkg::MODE_INDEX) mark(lisd_pkg::ST_BAD_HDR);
            default: ;
          endcase
          if (hidx == lisd_pkg::HI_MODE) begin
            if (hstat != 0) begin
              w = 0; h = 0; ch = 0;
              fail(hstat[2:0]);
            end else begin
              ev_on = 1; ev_kind = lisd_pkg::KIND_HEADER;
              hidx = 0; sec_no = 0; stage = lisd_pkg::PH_SEC_LEN;
            end
          end else begin
            hidx++;
          end
        end
        lisd_pkg::PH_SEC_LEN: begin
          shreg = {shreg[23:0], b};
          hidx++;
          if (hidx >= 4) begin
            sec_left = shreg;
            hidx = 0;
            if (sec_left == 0) section_done();
            else stage = lisd_pkg::PH_SEC_SKIP;
          end
        end
        lisd_pkg::PH_SEC_SKIP: begin
          sec_left--;
          if (sec_left == 0) section_done();
        end
        lisd_pkg::PH_COMP: begin
          shreg = {shreg[23:0], b};
          hidx++;
          if (hidx >= 2) begin
            v = shreg & 32'hFFFF;
            hidx = 0; chan = 0; row = 0; col = 0; base = 0;
            if (v > 1) fail(lisd_pkg::ST_BAD_COMP);
            else stage = (v == 0) ? lisd_pkg::PH_RAW : lisd_pkg::PH_LENS;
          end
        end
        lisd_pkg::PH_RAW: begin
          emit(1, b);
          col++;
          if (col >= w) void'(next_row());
        end
        lisd_pkg::PH_LENS: begin
          shreg = {shreg[23:0], b};
          hidx ^= 1;
          if (hidx == 0) begin
            idx = chan * h + row;
            if (idx < STORE_N) lens[idx[13:0]] = shreg[15:0];
            row++;
            if (row >= h) begin
              row = 0;
              chan++;
              if (chan >= ch) begin
                chan = 0; col = 0; base = 0;
                start_row();
              end
            end
          end
        end
        lisd_pkg::PH_CMD: begin
          if (row_left == 0) begin
            fail(lisd_pkg::ST_ROW_MISM);
          end else begin
            row_left--;
            if (b == lisd_pkg::PB_NOP) begin
              row_end_check();
            end else begin
              cnt = (b < 128) ? 32'(b) + 32'd1 : 32'(lisd_pkg::PB_REP_BASE) - 32'(b);
              need = (b < 128) ? cnt : 32'd1;
              if (need > row_left) fail(lisd_pkg::ST_ROW_MISM);
              else if (col > w || cnt > w - col) fail(lisd_pkg::ST_OVERRUN);
              else if (b < 128) begin
                lit_left = cnt; stage = lisd_pkg::PH_LIT;
              end else begin
                rep_cnt = cnt; stage = lisd_pkg::PH_REP;
              end
            end
          end
        end
        lisd_pkg::PH_LIT: begin
          row_left--;
          emit(1, b);
          col++;
          lit_left--;
          if (lit_left == 0) begin
            stage = lisd_pkg::PH_CMD;
            row_end_check();
          end
        end
        lisd_pkg::PH_REP: begin
          row_left--;
          emit(rep_cnt, b);
          col += rep_cnt;
          stage = lisd_pkg::PH_CMD;
          row_end_check();
        end
        default: ;
      endcase
      if (last && !(ev_on && ev_kind == lisd_pkg::KIND_FINAL))
        fail((stage == lisd_pkg::PH_HEADER) ? lisd_pkg::ST_BAD_HDR : lisd_pkg::ST_TRUNC);
      if (ev_on) begin
        r.kind = ev_kind;
        r.byte_address = ev_addr;
        r.run_length = ev_len[7:0];
        r.pixel_value = ev_val[7:0];
        r.status = ev_st;
        r.image_width = w[14:0];
        r.image_height = h[12:0];
        r.channel_count = ch[2:0];
        exp_q.push_back(r);
      end
      if (last) idle_all();
    endfunction

    function void check(lisd_pkg::res_t got);
      lisd_pkg::res_t e;
      if (exp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      e = exp_q.pop_front();
      if (got != e) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p, got %p", e, got);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [7:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [87:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  decode_scoreboard sb;
  bit [7:0] img[$];
  int cyc;
  int sent;

  layered_image_stream_decoder_core dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

  // no idling in this window
  function automatic bit quiet();
    return cyc >= 300 && cyc < 1100;
  endfunction

  always @(posedge clk) cyc <= cyc + 1;

  always @(posedge clk)
    if (rst_n && in_tvalid && in_tready) sb.step(in_tdata, in_tlast);

  always @(posedge clk) begin
    lisd_pkg::res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = lisd_pkg::kind_t'(out_tuser);
      got.byte_address = out_tdata[31:0];
      got.run_length = out_tdata[39:32];
      got.pixel_value = out_tdata[47:40];
      got.status = out_tdata[50:48];
      got.image_width = out_tdata[65:51];
      got.image_height = out_tdata[78:66];
      got.channel_count = out_tdata[81:79];
      sb.check(got);
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  initial begin
    int hold;
    hold = 0;
    out_tready <= 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_tready <= 0;
      end else if (cyc == 1500) begin
        hold = 400;
        out_tready <= 0;
      end else begin
        out_tready <= quiet() || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  function automatic void put8(bit [7:0] v);
    img.push_back(v);
  endfunction

  function automatic void put16(bit [15:0] v);
    put8(v[15:8]); put8(v[7:0]);
  endfunction

  function automatic void put32(bit [31:0] v);
    put16(v[31:16]); put16(v[15:0]);
  endfunction

  // One file into img. Pixel data only follows headers with small sane dimensions.
  function automatic void build(bit [31:0] fw, bit [31:0] fh, bit [15:0] fc, bit [15:0] fdep,
                                bit [15:0] fmode, bit [15:0] fcomp, bit force_cmds,
                                bit lens_err);
    int n, rem, k, start, bad_row;
    int rl[$];
    bit [7:0] body[$];
    bit [7:0] v;
    img.delete();
    put32(lisd_pkg::SIGNATURE);
    put16(16'($urandom));
    repeat (6) put8(8'($urandom));
    put16(fc); put32(fh); put32(fw); put16(fdep); put16(fmode);
    for (int s = 0; s < 3; s++) begin
      n = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      put32(32'(n));
      repeat (n) put8(8'($urandom));
    end
    put16(fcomp);
    if (fw < 1 || fw > 300 || fh < 1 || fh > 8 || fc < 1 || fc > 4 || fcomp > 1 ||
        fdep != lisd_pkg::DEPTH_8 || fmode == lisd_pkg::MODE_INDEX) begin
      repeat (3) put8(8'($urandom));
      return;
    end
    if (fcomp == 0) begin
      repeat (fw * fh * fc) put8(8'($urandom));
      return;
    end
    for (int r = 0; r < fc * fh; r++) begin
      start = body.size();
      rem = int'(fw);
      if (force_cmds && r == 0 && rem >= 256) begin
        body.push_back(lisd_pkg::PB_NOP);
        body.push_back(8'd127);
        repeat (128) body.push_back(8'($urandom));
        body.push_back(8'd129);
        body.push_back(8'($urandom));
        rem -= 256;
      end
      while (rem > 0) begin
        k = int'($urandom_range(0, 7));
        if (k == 0) begin
          body.push_back(lisd_pkg::PB_NOP);
        end else if (k < 4 || rem < 2) begin
          n = int'($urandom_range(1, (rem > 128) ? 128 : rem));
          v = 8'(n - 1);
          body.push_back(v);
          repeat (n) body.push_back(8'($urandom));
          rem -= n;
        end else begin
          n = int'($urandom_range(2, (rem > 128) ? 128 : rem));
          v = 8'(int'(lisd_pkg::PB_REP_BASE) - n);
          body.push_back(v);
          body.push_back(8'($urandom));
          rem -= n;
        end
      end
      rl.push_back(body.size() - start);
    end
    if (lens_err) begin
      bad_row = int'($urandom_range(0, rl.size() - 1));
      case ($urandom_range(0, 2))
        0: rl[bad_row] = 0;
        1: rl[bad_row] = rl[bad_row] + 1;
        default: rl[bad_row] = rl[bad_row] - 1;
      endcase
    end
    foreach (rl[i]) put16(16'(rl[i]));
    foreach (body[i]) put8(body[i]);
  endfunction

  task automatic send_file();
    for (int i = 0; i < img.size(); i++) begin
      if (!quiet() && $urandom_range(0, 99) < 19) begin
        in_tvalid <= 0;
        @(posedge clk);
      end
      in_tvalid <= 1;
      in_tdata <= img[i];
      in_tlast <= (i == img.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      sent++;
    end
    in_tvalid <= 0;
  endtask

  task automatic set_pitch(bit [19:0] p);
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {lisd_pkg::CFG_ROW_PITCH[0], 2'b00}; cfg_pwdata <= {12'h0, p};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    sb.pitch = 32'(p);
    @(posedge clk);
  endtask

  initial begin
    int w, h, c, mode, cut;
    bit [15:0] comp;
    sb = new();
    sent = 0;
    rst_n <= 0;
    in_tvalid <= 0; in_tdata <= 0; in_tlast <= 0;
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0; cfg_paddr <= 0; cfg_pwdata <= 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed files
    set_pitch(20'd0);
    build(1, 1, 1, lisd_pkg::DEPTH_8, 3, 0, 0, 0); send_file();
    set_pitch(20'hFFFFF);
    build(300, 1, 1, lisd_pkg::DEPTH_8, 3, 1, 1, 0); send_file();
    build(3, 2, 2, lisd_pkg::DEPTH_8, 3, 1, 0, 0); send_file();
    // bad signature
    build(2, 2, 1, lisd_pkg::DEPTH_8, 3, 0, 0, 0); img[1] = 8'h00; send_file();
    build(2, 2, 0, lisd_pkg::DEPTH_8, 3, 0, 0, 0); send_file();
    build(2, 2, 5, lisd_pkg::DEPTH_8, 3, 0, 0, 0); send_file();
    build(2, 2, 1, 16'd16, 3, 0, 0, 0); send_file();
    build(2, 2, 1, lisd_pkg::DEPTH_8, lisd_pkg::MODE_INDEX, 0, 0, 0); send_file();
    build(0, 2, 1, lisd_pkg::DEPTH_8, 3, 0, 0, 0); send_file();
    build(MAX_W + 1, 2, 1, lisd_pkg::DEPTH_8, 3, 0, 0, 0); send_file();
    build(2, MAX_H + 1, 1, lisd_pkg::DEPTH_8, 3, 0, 0, 0); send_file();
    build(32'h8000_0001, 2, 1, lisd_pkg::DEPTH_8, 3, 0, 0, 0); send_file();
    // truncated in the data
    build(MAX_W, MAX_H, 4, lisd_pkg::DEPTH_8, 3, 0, 0, 0); send_file();
    build(2, 2, 1, lisd_pkg::DEPTH_8, 3, 16'hFFFF, 0, 0); send_file();
    // ends mid header
    build(2, 2, 1, lisd_pkg::DEPTH_8, 3, 0, 0, 0); img = img[0:9]; send_file();
    build(4, 2, 2, lisd_pkg::DEPTH_8, 3, 1, 0, 1);
    repeat (3) img.push_back(8'($urandom));
    send_file();
    set_pitch(20'($urandom));
    build(3, 1, 1, lisd_pkg::DEPTH_8, 3, 0, 0, 0);
    repeat (4) img.push_back(8'($urandom));
    send_file();

    while (sent < N_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: set_pitch(20'd0);
          1: set_pitch(20'hFFFFF);
          default: set_pitch(20'($urandom_range(0, 64)));
        endcase
      end
      mode = int'($urandom_range(0, 9));
      if ($urandom_range(0, 9) == 0) begin
        w = int'($urandom_range(100, 300)); h = 1; c = 1;
      end else begin
        w = int'($urandom_range(1, 12)); h = int'($urandom_range(1, 3));
        c = int'($urandom_range(1, 4));
      end
      comp = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(2, 65535))
                                          : 16'($urandom_range(0, 1));
      build(32'(w), 32'(h), 16'(c), lisd_pkg::DEPTH_8,
            $urandom_range(0, 1) ? 16'd3 : 16'($urandom), comp, 0, mode == 8);
      case (mode)
        6: img[$urandom_range(0, img.size() - 1)] = 8'($urandom);
        7: begin
          cut = int'($urandom_range(1, img.size() - 1));
          img = img[0:cut - 1];
        end
        9: repeat ($urandom_range(1, 4)) img.push_back(8'($urandom));
        default: ;
      endcase
      send_file();
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
